@@ rtl/btor_pkg.sv @@
package btor_pkg;

  typedef enum logic [1:0] {
    CMD_BEGIN_LINE = 2'd0,
    CMD_DRAW_CHAR  = 2'd1,
    CMD_END_LINE   = 2'd2,
    CMD_UNUSED     = 2'd3
  } command_t;

  // Configuration register indexes.
  localparam int REG_END_X = 0;
  localparam int REG_TOP_Y = 1;

  localparam int GLYPH_COUNT = 40;
  localparam int GLYPH_BITS_W = 28;

  localparam logic [5:0] GLYPH_LETTER_BASE = 6'h0A;
  localparam logic [5:0] GLYPH_DOT         = 6'h24;
  localparam logic [5:0] GLYPH_COLON       = 6'h25;
  localparam logic [5:0] GLYPH_DASH        = 6'h26;
  localparam logic [5:0] GLYPH_SPACE       = 6'h27;

  localparam logic [2:0] LAST_ROW = 3'd4;

  localparam int TOP_ROW    = 10;
  localparam int WRAP_ROW   = 205;
  localparam int COLUMN_GAP = 4;
  localparam int CHAR_GAP   = 2;
  localparam int LINE_GAP   = 2;
  localparam int GLYPH_ROWS = 5;

  localparam logic [15:0] BLACK = 16'h0001;

  localparam logic [2:0] GLYPH_WIDTH [GLYPH_COUNT] = '{
    3'd3, 3'd1, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd5, 3'd4, 3'd4, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd5, 3'd5, 3'd3, 3'd3, 3'd4, 3'd1, 3'd1, 3'd3, 3'd2
  };

  // Cells are packed row-major; the first cell is the top bit.
  localparam logic [GLYPH_BITS_W-1:0] GLYPH_BITS [GLYPH_COUNT] = '{
    28'hF6DE000, 28'hF800000, 28'hC4AE000, 28'hE59E000, 28'h88AF200,
    28'hF39E000, 28'hF3DE000, 28'hE4A4000, 28'hF7DE000, 28'hF79E000,
    28'hF6FA000, 28'hD75C000, 28'hF24E000, 28'hD6DC000, 28'hF34E000,
    28'hF348000, 28'hF25E000, 28'hB7DA000, 28'hE92E000, 28'hE928000,
    28'hB75A000, 28'h924E000, 28'h8EEB188, 28'h9DFB900, 28'h6999600,
    28'hF7C8000, 28'h69DB700, 28'hF7EA000, 28'hF39E000, 28'hE924000,
    28'h9999600, 28'h8C62A20, 28'h8C63550, 28'hB55A000, 28'hB79E000,
    28'hF124F00, 28'h0800000, 28'h5000000, 28'h0380000, 28'h0000000
  };

  // Green, cyan, yellow, pink, red, orange, white, red.
  localparam logic [15:0] PALETTE [8] = '{
    16'h07C1, 16'h07FF, 16'hFFC1, 16'hF83F,
    16'hF801, 16'hFC01, 16'hFFFF, 16'hF801
  };

  typedef struct packed {
    logic load;
    logic emit;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic draws;
    logic out_free;
    logic cell_last;
  } dp_status_t;

  function automatic logic [5:0] glyph_of(input logic [7:0] c);
    logic [5:0] g;
    g = GLYPH_SPACE;
    if (c >= 8'h61 && c <= 8'h7A) begin
      g = 6'(c - 8'h61) + GLYPH_LETTER_BASE;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      g = 6'(c - 8'h41) + GLYPH_LETTER_BASE;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      g = 6'(c - 8'h30);
    end else if (c == 8'h2E) begin
      g = GLYPH_DOT;
    end else if (c == 8'h3A) begin
      g = GLYPH_COLON;
    end else if (c == 8'h2D) begin
      g = GLYPH_DASH;
    end
    return g;
  endfunction

endpackage

@@ rtl/btor_in_if.sv @@
interface btor_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] character;
  logic [2:0] color_select;
  logic [2:0] font_size;

  modport source (output valid, command, character, color_select, font_size, input ready);
  modport sink (input valid, command, character, color_select, font_size, output ready);
endinterface

@@ rtl/btor_out_if.sv @@
interface btor_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] rect_x;
  logic [11:0] rect_y;
  logic [3:0]  rect_side;
  logic [15:0] fill_color;
  logic        last;

  modport source (output valid, rect_x, rect_y, rect_side, fill_color, last, input ready);
  modport sink (input valid, rect_x, rect_y, rect_side, fill_color, last, output ready);
endinterface

@@ rtl/btor_ctrl.sv @@
module btor_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  btor_pkg::dp_status_t  status,
  output btor_pkg::dp_cmd_t     cmd
);
  import btor_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_UPDATE
  } state_t;

  state_t state;

  always_comb begin
    cmd.load   = (state == S_IDLE) && in_valid && in_ready;
    cmd.emit   = (state == S_EMIT) && status.draws && status.out_free;
    cmd.update = (state == S_UPDATE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_EMIT;
            in_ready <= 1'b0;
          end else begin
            in_ready <= 1'b1;
          end
        end
        S_EMIT: begin
          // Commands that draw nothing fall straight through to the update.
          if (!status.draws || (status.out_free && status.cell_last)) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ rtl/btor_datapath.sv @@
module btor_datapath #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  btor_pkg::dp_cmd_t     cmd,
  output btor_pkg::dp_status_t  status,
  input  logic [1:0]            command,
  input  logic [7:0]            character,
  input  logic [2:0]            color_select,
  input  logic [2:0]            font_size,
  input  logic [11:0]           end_x_cfg,
  input  logic [11:0]           top_y_cfg,
  output logic                  rect_valid,
  input  logic                  rect_ready,
  output logic [11:0]           rect_x,
  output logic [11:0]           rect_y,
  output logic [3:0]            rect_side,
  output logic [15:0]           fill_color,
  output logic                  last
);
  import btor_pkg::*;

  localparam int CMP_BITS = (COORD_BITS > 12) ? COORD_BITS : 12;
  localparam logic signed [CMP_BITS-1:0] WRAP_C = CMP_BITS'(WRAP_ROW);

  typedef logic [COORD_BITS-1:0] coord_t;

  // Text state
  coord_t cursor_x, line_start_x, line_top_y, longest_line_x;

  // Per-item sequencing
  command_t   cmd_q;
  logic       draw_pass;
  logic [2:0] cell_row, cell_column;

  // Item payload
  logic [5:0]              glyph_q;
  logic [2:0]              fs_q;
  logic [15:0]             color_q;
  coord_t                  x0_q, x_acc, y_acc;
  logic [GLYPH_BITS_W-1:0] shift_bits;

  logic [2:0] fs_eff, width_q;
  logic [5:0] glyph_load;
  coord_t     x0_in;
  logic       grow, col_last, row_last;
  logic [5:0] advance, line_step;
  coord_t     longest_upd, top_next, start_wrap, top_wrap;
  logic       wrap;

  always_comb begin
    fs_eff     = (font_size == 3'd0) ? 3'd1 : font_size;
    glyph_load = (command == CMD_END_LINE) ? GLYPH_SPACE : glyph_of(character);
    x0_in      = (command == CMD_END_LINE) ? cursor_x - coord_t'(1) : cursor_x;

    width_q  = GLYPH_WIDTH[glyph_q];
    grow     = !draw_pass;
    col_last = (cell_column == width_q - 3'd1);
    row_last = (cell_row == LAST_ROW);

    status.draws     = (cmd_q == CMD_DRAW_CHAR) || (cmd_q == CMD_END_LINE);
    status.out_free  = !rect_valid || rect_ready;
    status.cell_last = draw_pass && row_last && col_last;

    advance   = 6'(width_q) * 6'(fs_q);
    line_step = 6'(fs_q) * 6'(GLYPH_ROWS) + 6'(LINE_GAP);

    longest_upd = ($signed(cursor_x) >= $signed(longest_line_x)) ? cursor_x : longest_line_x;
    top_next    = line_top_y + coord_t'(line_step);
    wrap        = CMP_BITS'(signed'(top_next)) >= WRAP_C;
    start_wrap  = longest_upd + coord_t'(COLUMN_GAP);
    // A wrapped column starts high up only when it clears the large value.
    top_wrap    = (CMP_BITS'(signed'(end_x_cfg)) < CMP_BITS'(signed'(start_wrap))) ?
                  coord_t'(TOP_ROW) : coord_t'(signed'(top_y_cfg));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x       <= '0;
      line_start_x   <= '0;
      line_top_y     <= '0;
      longest_line_x <= '0;
      cmd_q          <= CMD_UNUSED;
      draw_pass      <= 1'b0;
      cell_row       <= '0;
      cell_column    <= '0;
      rect_valid     <= 1'b0;
    end else begin
      if (cmd.load) begin
        cmd_q       <= command_t'(command);
        draw_pass   <= 1'b0;
        cell_row    <= '0;
        cell_column <= '0;
      end else if (cmd.emit) begin
        if (col_last) begin
          cell_column <= '0;
          if (row_last) begin
            cell_row  <= '0;
            draw_pass <= !draw_pass;
          end else begin
            cell_row <= cell_row + 3'd1;
          end
        end else begin
          cell_column <= cell_column + 3'd1;
        end
      end

      if (cmd.emit) begin
        rect_valid <= 1'b1;
      end else if (rect_ready) begin
        rect_valid <= 1'b0;
      end

      if (cmd.update) begin
        case (cmd_q)
          CMD_BEGIN_LINE: begin
            cursor_x <= line_start_x;
          end
          CMD_DRAW_CHAR: begin
            cursor_x <= cursor_x + coord_t'(advance) + coord_t'(CHAR_GAP);
          end
          CMD_END_LINE: begin
            if (wrap) begin
              line_start_x   <= start_wrap;
              cursor_x       <= start_wrap;
              line_top_y     <= top_wrap;
              longest_line_x <= '0;
            end else begin
              longest_line_x <= longest_upd;
              line_top_y     <= top_next;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      glyph_q    <= glyph_load;
      fs_q       <= fs_eff;
      color_q    <= PALETTE[color_select];
      x0_q       <= x0_in;
      x_acc      <= x0_in - coord_t'(1);
      y_acc      <= line_top_y - coord_t'(1);
      shift_bits <= GLYPH_BITS[glyph_load];
    end else if (cmd.emit) begin
      if (col_last) begin
        if (row_last) begin
          // The second pass restarts at the unexpanded origin.
          x_acc      <= x0_q;
          y_acc      <= line_top_y;
          shift_bits <= GLYPH_BITS[glyph_q];
        end else begin
          x_acc      <= x0_q - coord_t'(grow);
          y_acc      <= y_acc + coord_t'(fs_q);
          shift_bits <= shift_bits << 1;
        end
      end else begin
        x_acc      <= x_acc + coord_t'(fs_q);
        shift_bits <= shift_bits << 1;
      end
    end

    if (cmd.emit) begin
      rect_x     <= 12'(signed'(x_acc));
      rect_y     <= 12'(signed'(y_acc));
      rect_side  <= 4'(fs_q) + (grow ? 4'd2 : 4'd0);
      fill_color <= (draw_pass && shift_bits[GLYPH_BITS_W-1]) ? color_q : BLACK;
      last       <= status.cell_last;
    end
  end

endmodule

@@ rtl/bitmap_text_overlay_renderer.sv @@
// Text overlay renderer: each command on the item channel is turned into a
// stream of filled squares on the rectangle channel, one square per cycle
// when the sink keeps ready high. A draw-character or end-line command makes
// ten squares per glyph column (two passes of five rows), so 10 to 50
// squares; begin-line and unused commands make none. The block handles one
// command at a time: it loads the command, its cell sequencer steps one glyph
// cell per square, and it then updates the cursor and line state before it
// takes the next command. Back-pressure on the rectangle channel stalls the
// cell sequencer. The APB registers hold the large-value geometry used when
// text wraps into a new column; they should be written only while the block
// is idle.
module bitmap_text_overlay_renderer #(
  parameter int COORD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  btor_in_if.sink     items,
  btor_out_if.source  rects,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import btor_pkg::*;

  logic [11:0] large_value_end_x, large_value_top_y;
  logic        cfg_write;
  logic        cfg_sel;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign pready    = 1'b1;
  assign cfg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (cfg_sel == 1'(REG_TOP_Y)) ? 32'(large_value_top_y) :
                     32'(large_value_end_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      large_value_end_x <= '0;
      large_value_top_y <= '0;
    end else if (cfg_write) begin
      if (cfg_sel == 1'(REG_END_X)) begin
        large_value_end_x <= pwdata[11:0];
      end else begin
        large_value_top_y <= pwdata[11:0];
      end
    end
  end

  btor_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  btor_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (dp_cmd),
    .status       (dp_status),
    .command      (items.command),
    .character    (items.character),
    .color_select (items.color_select),
    .font_size    (items.font_size),
    .end_x_cfg    (large_value_end_x),
    .top_y_cfg    (large_value_top_y),
    .rect_valid   (rects.valid),
    .rect_ready   (rects.ready),
    .rect_x       (rects.rect_x),
    .rect_y       (rects.rect_y),
    .rect_side    (rects.rect_side),
    .fill_color   (rects.fill_color),
    .last         (rects.last)
  );

`ifndef SYNTH
  // The sequencer works on one command at a time.
  assert property (@(posedge clk) disable iff (rst)
    items.valid && items.ready |=> !items.ready)
    else $error("command accepted while another is in progress");

  // Within one glyph the squares follow each other without a gap.
  assert property (@(posedge clk) disable iff (rst)
    rects.valid && rects.ready && !rects.last |=> rects.valid)
    else $error("gap in square stream before the final square");

  assert property (@(posedge clk) disable iff (rst)
    rects.valid |-> (rects.rect_side >= 4'd1 && rects.rect_side <= 4'd9))
    else $error("square side out of range");
`endif

endmodule
